FILE: design/tce_pkg.sv
package tce_pkg;

   localparam int NUM_REGS   = 8;
   localparam int REG_IDX_W  = $clog2(NUM_REGS);
   localparam int DATA_W     = 8;
   localparam int WORD_W     = 20;
   localparam int WAIT_W     = 4;
   localparam int TICK_W     = 32;
   localparam int CSR_IDX_W  = 2;

   localparam int OP_SHIFT   = 17;
   localparam int D_SHIFT    = 14;
   localparam int S_SHIFT    = 11;
   localparam int T_SHIFT    = 8;

   localparam int REQ_DATA_W = 32;
   localparam int RSP_DATA_W = 72;

   localparam logic [WAIT_W-1:0] HIT_WAIT     = WAIT_W'(1);
   localparam logic [WAIT_W-1:0] MISS_WAIT_RV = WAIT_W'(5);
   localparam logic [WAIT_W-1:0] MUL_WAIT_RV  = WAIT_W'(2);
   localparam logic [WAIT_W-1:0] BR_WAIT_RV   = WAIT_W'(2);

   typedef enum logic [2:0] {
      OP_ADD    = 3'd0,
      OP_ADDI   = 3'd1,
      OP_MUL    = 3'd2,
      OP_INV    = 3'd3,
      OP_BRANCH = 3'd4,
      OP_LOAD   = 3'd5,
      OP_STORE  = 3'd6,
      OP_HALT   = 3'd7
   } opcode_type;

   typedef enum logic [2:0] {
      BR_EQ = 3'd0,
      BR_NE = 3'd1,
      BR_LT = 3'd2
   } branch_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MISS_WAIT   = 2'd0,
      CSR_MUL_WAIT    = 2'd1,
      CSR_BRANCH_WAIT = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [WAIT_W-1:0] miss_wait;
      logic [WAIT_W-1:0] mul_wait;
      logic [WAIT_W-1:0] branch_wait;
   } cfg_type;

   typedef struct packed {
      logic [DATA_W-1:0] pc;
      logic [WAIT_W-1:0] wait_count;
      logic              halt;
   } cpu_state_type;

   typedef struct packed {
      logic                 executed;
      logic                 mem_read;
      logic                 mem_write;
      logic [DATA_W-1:0]    mem_addr;
      logic [DATA_W-1:0]    mem_wdata;
      logic                 reg_write;
      logic [REG_IDX_W-1:0] reg_index;
      logic [DATA_W-1:0]    reg_value;
   } exec_result_type;

   // a zero setting is treated as HIT_WAIT
   function automatic logic [WAIT_W-1:0] wait_of(input logic [WAIT_W-1:0] v);
      return (v == '0) ? HIT_WAIT : v;
   endfunction

endpackage

FILE: design/tce_ram.sv
module tce_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 8
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
   input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
   output logic [WIDTH-1:0]         rd_data_a,
   output logic [WIDTH-1:0]         rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_a <= mem[rd_addr_a];
         rd_data_b <= mem[rd_addr_b];
      end
   end

endmodule

FILE: design/tce_exec.sv
module tce_exec
   import tce_pkg::*;
(
   input  logic [WORD_W-1:0] word,
   input  logic [DATA_W-1:0] load_data,
   input  logic              cache_hit,
   input  logic [DATA_W-1:0] vs,
   input  logic [DATA_W-1:0] vt,
   input  cfg_type           cfg,
   input  cpu_state_type     state,
   output cpu_state_type     state_next,
   output exec_result_type   result
);

   opcode_type           op;
   logic [2:0]           sub;
   logic [REG_IDX_W-1:0] d_idx;
   logic [DATA_W-1:0]    imm;
   logic [DATA_W-1:0]    pc_inc;
   logic                 taken;
   logic                 br_valid;

   assign op     = opcode_type'(word[OP_SHIFT +: 3]);
   assign sub    = word[D_SHIFT +: 3];
   assign d_idx  = word[D_SHIFT +: REG_IDX_W];
   assign imm    = word[DATA_W-1:0];
   assign pc_inc = state.pc + DATA_W'(1);

   always_comb begin
      taken    = 1'b0;
      br_valid = 1'b1;
      case (sub)
         BR_EQ:   taken = (vs == vt);
         BR_NE:   taken = (vs != vt);
         BR_LT:   taken = (vs < vt);
         default: br_valid = 1'b0;
      endcase
   end

   always_comb begin
      state_next = state;
      result     = '0;
      if (!state.halt) begin
         if (state.wait_count == HIT_WAIT) begin
            result.executed = 1'b1;
            if (word != '0) begin
               state_next.pc = pc_inc;
               unique case (op)
                  OP_ADD: begin
                     result.reg_write = 1'b1;
                     result.reg_value = vs + vt;
                  end
                  OP_ADDI: begin
                     result.reg_write = 1'b1;
                     result.reg_value = vs + imm;
                  end
                  OP_MUL: begin
                     result.reg_write      = 1'b1;
                     result.reg_value      = DATA_W'(vs[3:0] * vs[7:4]);
                     state_next.wait_count = wait_of(cfg.mul_wait);
                  end
                  OP_INV: begin
                     result.reg_write = 1'b1;
                     result.reg_value = ~vs;
                  end
                  OP_BRANCH: begin
                     if (!br_valid) begin
                        state_next.pc = state.pc;
                     end else if (taken) begin
                        state_next.pc         = imm;
                        state_next.wait_count = wait_of(cfg.branch_wait);
                     end
                  end
                  OP_LOAD: begin
                     result.mem_read       = 1'b1;
                     result.mem_addr       = vt;
                     result.reg_write      = 1'b1;
                     result.reg_value      = load_data;
                     state_next.wait_count = cache_hit ? HIT_WAIT : wait_of(cfg.miss_wait);
                  end
                  OP_STORE: begin
                     result.mem_write      = 1'b1;
                     result.mem_addr       = vt;
                     result.mem_wdata      = vs;
                     state_next.wait_count = cache_hit ? HIT_WAIT : wait_of(cfg.miss_wait);
                  end
                  OP_HALT: state_next.halt = 1'b1;
                  default: state_next = state;
               endcase
               if (result.reg_write) begin
                  result.reg_index = d_idx;
               end
            end
         end else begin
            state_next.wait_count = state.wait_count - WAIT_W'(1);
         end
      end
   end

endmodule

FILE: design/tiny_cpu_execute_step_top.sv
// One CPU tick per request transfer, one response per tick. Ticks are taken
// back to back: a request is accepted every clock while responses drain, and
// each tick passes through the execute stage (register read data, decode and
// ALU) before landing in the response register. Register reads are issued
// from the incoming word on acceptance, with write-through forwarding from
// the tick in flight, so dependent instructions do not stall. Wait counts and
// halt follow the emulated CPU and never throttle the stream. The eight
// registers read as zero until first written; no clearing pass is needed.
module tiny_cpu_execute_step_top
   import tce_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   // instr_word[19:0], load_data[27:20], cache_hit[28], zero pad
   input  logic [REQ_DATA_W-1:0] req_tdata,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   // executed[0], pc_value[8:1], mem_read[9], mem_write[10], mem_addr[18:11],
   // mem_wdata[26:19], reg_write[27], reg_index[30:28], reg_value[38:31],
   // halted[39], tick_count[71:40]
   output logic [RSP_DATA_W-1:0] rsp_tdata,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [WAIT_W-1:0]     csr_wdata
);

   cfg_type              cfg_ff;
   cpu_state_type        state_ff;
   cpu_state_type        state_in;
   logic [TICK_W-1:0]    ticks_ff;
   logic [TICK_W-1:0]    ticks_in;
   logic [NUM_REGS-1:0]  reg_valid_ff;

   logic                 stage_valid_ff;
   logic [WORD_W-1:0]    stage_word_ff;
   logic [DATA_W-1:0]    stage_ldata_ff;
   logic                 stage_hit_ff;
   logic                 fwd_s_ff;
   logic                 fwd_t_ff;
   logic                 vld_s_ff;
   logic                 vld_t_ff;
   logic [DATA_W-1:0]    fwd_val_ff;

   logic                 out_valid_ff;
   logic [RSP_DATA_W-1:0] out_data_ff;

   logic                 req_fire;
   logic                 stage_fire;
   logic                 wr_en;
   logic [REG_IDX_W-1:0] req_s;
   logic [REG_IDX_W-1:0] req_t;
   logic [DATA_W-1:0]    ram_s;
   logic [DATA_W-1:0]    ram_t;
   logic [DATA_W-1:0]    vs;
   logic [DATA_W-1:0]    vt;
   exec_result_type      res;

   assign stage_fire = stage_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !stage_valid_ff || stage_fire;
   assign req_fire   = req_tvalid && req_tready;
   assign req_s      = req_tdata[S_SHIFT +: REG_IDX_W];
   assign req_t      = req_tdata[T_SHIFT +: REG_IDX_W];
   assign wr_en      = stage_fire && res.reg_write;
   assign ticks_in   = ticks_ff + TICK_W'(1);

   tce_ram #(
      .WIDTH (DATA_W),
      .DEPTH (NUM_REGS)
   ) u_regs (
      .clock     (clock),
      .wr_en     (wr_en),
      .wr_addr   (res.reg_index),
      .wr_data   (res.reg_value),
      .rd_en     (req_fire),
      .rd_addr_a (req_s),
      .rd_addr_b (req_t),
      .rd_data_a (ram_s),
      .rd_data_b (ram_t)
   );

   assign vs = fwd_s_ff ? fwd_val_ff : (vld_s_ff ? ram_s : '0);
   assign vt = fwd_t_ff ? fwd_val_ff : (vld_t_ff ? ram_t : '0);

   tce_exec u_exec (
      .word       (stage_word_ff),
      .load_data  (stage_ldata_ff),
      .cache_hit  (stage_hit_ff),
      .vs         (vs),
      .vt         (vt),
      .cfg        (cfg_ff),
      .state      (state_ff),
      .state_next (state_in),
      .result     (res)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.miss_wait   <= MISS_WAIT_RV;
         cfg_ff.mul_wait    <= MUL_WAIT_RV;
         cfg_ff.branch_wait <= BR_WAIT_RV;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_MISS_WAIT:   cfg_ff.miss_wait   <= csr_wdata;
            CSR_MUL_WAIT:    cfg_ff.mul_wait    <= csr_wdata;
            CSR_BRANCH_WAIT: cfg_ff.branch_wait <= csr_wdata;
            default:         cfg_ff             <= cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.pc         <= '0;
         state_ff.wait_count <= HIT_WAIT;
         state_ff.halt       <= 1'b0;
         ticks_ff            <= '0;
         reg_valid_ff        <= '0;
      end else if (stage_fire) begin
         state_ff <= state_in;
         ticks_ff <= ticks_in;
         if (res.reg_write) begin
            reg_valid_ff[res.reg_index] <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_valid_ff <= 1'b0;
      end else if (req_tready) begin
         stage_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         stage_word_ff  <= req_tdata[WORD_W-1:0];
         stage_ldata_ff <= req_tdata[WORD_W +: DATA_W];
         stage_hit_ff   <= req_tdata[WORD_W + DATA_W];
         fwd_s_ff       <= wr_en && (res.reg_index == req_s);
         fwd_t_ff       <= wr_en && (res.reg_index == req_t);
         vld_s_ff       <= reg_valid_ff[req_s];
         vld_t_ff       <= reg_valid_ff[req_t];
         fwd_val_ff     <= res.reg_value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (stage_fire) begin
         out_valid_ff <= 1'b1;
      end else if (rsp_tready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_fire) begin
         out_data_ff <= {ticks_in, state_in.halt, res.reg_value, res.reg_index,
                         res.reg_write, res.mem_wdata, res.mem_addr, res.mem_write,
                         res.mem_read, state_in.pc, res.executed};
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_data_ff;

   a_halt_sticks: assert property (@(posedge clock) disable iff (reset)
      state_ff.halt |=> state_ff.halt)
      else $error("halt flag cleared");

   a_wait_nonzero: assert property (@(posedge clock) disable iff (reset)
      state_ff.wait_count != '0)
      else $error("wait count reached zero");

   a_idle_pc_holds: assert property (@(posedge clock) disable iff (reset)
      stage_fire && !res.executed |=> state_ff.pc == $past(state_ff.pc))
      else $error("pc moved without a fetch");

   a_fire_fills_out: assert property (@(posedge clock) disable iff (reset)
      stage_fire |=> out_valid_ff)
      else $error("tick lost on its way to the response register");

endmodule
